FILE: sv/filtered_nearest_object_search_macros.svh
// Assertion macros shared by the nearest-object search RTL.
// Needs clk and rst in the scope of the module that uses them.
`ifndef FILTERED_NEAREST_OBJECT_SEARCH_MACROS_SVH
`define FILTERED_NEAREST_OBJECT_SEARCH_MACROS_SVH

// Check that a property holds at every clock edge outside reset.
`define FNOS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Check that a condition never occurs outside reset.
`define FNOS_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);

`endif

FILE: sv/fnos_pkg.sv
// Shared types and constants for the filtered nearest-object search.
// No dependencies; imported by every module of the block.
`default_nettype none

package fnos_pkg;

  localparam int CFG_W     = 32;
  localparam int CFG_IDX_W = 3;
  localparam int QDEPTH    = 8;
  localparam int QPTR_W    = 3;
  localparam int QCNT_W    = 4;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_REF_X       = 3'd0,
    REG_REF_Y       = 3'd1,
    REG_COLOUR_ON   = 3'd2,
    REG_OWN_RED     = 3'd3,
    REG_RANGE_LIMIT = 3'd4,
    REG_AGE_LIMIT   = 3'd5,
    REG_NOW         = 3'd6
  } cfg_reg_t;

  // One classified object handed from front to back
  typedef struct packed {
    logic        pass;   // candidate and all filters passed
    logic        last;   // ends the list
    logic [7:0]  pos;    // low bits of list position
    logic [32:0] d2;     // squared distance, mm^2
  } queue_entry_t;

  // Front pipeline output toward the queue
  typedef struct packed {
    logic         valid;
    queue_entry_t entry;
  } front_push_t;

endpackage

`default_nettype wire

FILE: sv/filtered_nearest_object_search.sv
// Filtered nearest-object search, top level.
// Channels: objects enter on in_valid/in_stall, one word per object; the word
//   with last_item set closes a list. One result word per list leaves on
//   out_valid/out_stall: found, best_index and best_dist_sq (all zero if no
//   object passed the colour, age and range filters).
// Configuration: cfg_we with cfg_index and cfg_data writes one register in a
//   cycle; write only while no list is in progress and all results are out.
// Throughput: one object per cycle while in_stall is low. The front classifies
//   in a 3-stage pipeline, an 8-entry queue feeds the back, which folds one
//   object a cycle into the running minimum but holds a last word on a stall.
// Path: the last object of a list passes the three front stages, the queue
//   and the result register before its result shows on out_valid.
// Stall: out_stall holds the result register; the back then stops at the
//   next last word, the queue fills and in_stall rises once queue words plus
//   pipeline words reach the queue depth.
// Reset (rst, synchronous): clear the search state and restore register
//   defaults (colour filter on, own colour red, all else zero).
// Objects past MAX_OBJECTS in a list are skipped but last_item still ends it.
`default_nettype none

module filtered_nearest_object_search #(
  parameter int MAX_OBJECTS = 256
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           cfg_we,
  input  wire logic [fnos_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [fnos_pkg::CFG_W-1:0]      cfg_data,
  input  wire logic                           in_valid,
  output logic                                in_stall,
  input  wire logic signed [15:0]             obj_x_mm,
  input  wire logic signed [15:0]             obj_y_mm,
  input  wire logic                           obj_red,
  input  wire logic [31:0]                    seen_ms,
  input  wire logic                           last_item,
  output logic                                out_valid,
  input  wire logic                           out_stall,
  output logic                                found,
  output logic [7:0]                          best_index,
  output logic [33:0]                         best_dist_sq
);
  import fnos_pkg::*;

  front_push_t          push;
  logic [1:0]           inflight;
  queue_entry_t         head;
  logic                 head_valid;
  logic                 pop;
  logic [QCNT_W-1:0]    q_count;
  logic [QCNT_W:0]      occupancy;
  logic                 take;

  // Count words in the pipeline as already queued so none is ever dropped
  assign occupancy = {1'b0, q_count} + {{(QCNT_W-1){1'b0}}, inflight};
  assign in_stall  = occupancy >= (QCNT_W+1)'(QDEPTH);
  assign take      = in_valid && !in_stall;

  fnos_front #(
    .MAX_OBJECTS (MAX_OBJECTS)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .take      (take),
    .obj_x_mm  (obj_x_mm),
    .obj_y_mm  (obj_y_mm),
    .obj_red   (obj_red),
    .seen_ms   (seen_ms),
    .last_item (last_item),
    .push      (push),
    .inflight  (inflight)
  );

  fnos_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .pop        (pop),
    .head       (head),
    .head_valid (head_valid),
    .count      (q_count)
  );

  fnos_back u_back (
    .clk          (clk),
    .rst          (rst),
    .head         (head),
    .head_valid   (head_valid),
    .pop          (pop),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .found        (found),
    .best_index   (best_index),
    .best_dist_sq (best_dist_sq)
  );

endmodule

`default_nettype wire

FILE: sv/fnos_queue.sv
// Small FIFO of classified objects between front and back.
// Depends on fnos_pkg and the shared assertion macros.
`default_nettype none
`include "filtered_nearest_object_search_macros.svh"

module fnos_queue (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire fnos_pkg::front_push_t push,
  input  wire logic                 pop,
  output fnos_pkg::queue_entry_t    head,
  output logic                      head_valid,
  output logic [fnos_pkg::QCNT_W-1:0] count
);
  import fnos_pkg::*;

  queue_entry_t             mem [QDEPTH];
  logic [QPTR_W-1:0]        wr_ptr;
  logic [QPTR_W-1:0]        rd_ptr;
  logic                     do_pop;

  assign do_pop     = pop && (count != '0);
  assign head       = mem[rd_ptr];
  assign head_valid = (count != '0);

  always_ff @(posedge clk) begin
    if (push.valid) begin
      mem[wr_ptr] <= push.entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push.valid) begin
        wr_ptr <= wr_ptr + QPTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + QPTR_W'(1);
      end
      case ({push.valid, do_pop})
        2'b10:   count <= count + QCNT_W'(1);
        2'b01:   count <= count - QCNT_W'(1);
        default: count <= count;
      endcase
    end
  end

  `FNOS_NEVER(a_no_overflow, push.valid && !do_pop && (count == QCNT_W'(QDEPTH)), "queue overflow")
  `FNOS_NEVER(a_count_bound, count > QCNT_W'(QDEPTH), "queue count beyond depth")
  `FNOS_NEVER(a_no_underflow, pop && (count == '0), "pop from empty queue")

endmodule

`default_nettype wire

FILE: sv/fnos_front.sv
// Front end: configuration registers, item counter and a three-stage
// classification pipeline (filters, squares, distance sum). Uses fnos_pkg.
`default_nettype none

module fnos_front #(
  parameter int MAX_OBJECTS = 256
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          cfg_we,
  input  wire logic [fnos_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [fnos_pkg::CFG_W-1:0]     cfg_data,
  input  wire logic                          take,
  input  wire logic signed [15:0]            obj_x_mm,
  input  wire logic signed [15:0]            obj_y_mm,
  input  wire logic                          obj_red,
  input  wire logic [31:0]                   seen_ms,
  input  wire logic                          last_item,
  output fnos_pkg::front_push_t              push,
  output logic [1:0]                         inflight
);
  import fnos_pkg::*;

  localparam int CNT_W = $clog2(MAX_OBJECTS + 1);

  // Configuration
  logic signed [15:0] ref_x_mm;
  logic signed [15:0] ref_y_mm;
  logic               colour_filter_on;
  logic               own_colour_red;
  logic [15:0]        range_limit_mm;
  logic [31:0]        age_limit_ms;
  logic [31:0]        now_ms;
  logic [31:0]        range_sq;

  // Item counter
  logic [CNT_W-1:0]   item_counter;
  logic               cand;
  logic [CNT_W+7:0]   cnt_ext;

  // Stage 1
  logic               v1;
  logic signed [16:0] dx1;
  logic signed [16:0] dy1;
  logic               ok1;
  logic               last1;
  logic [7:0]         pos1;
  // Stage 2
  logic               v2;
  logic [31:0]        sqx2;
  logic [31:0]        sqy2;
  logic               ok2;
  logic               last2;
  logic [7:0]         pos2;
  // Stage 3
  logic               v3;
  queue_entry_t       ent3;

  logic signed [16:0] dx_next;
  logic signed [16:0] dy_next;
  logic [32:0]        age_diff;
  logic               age_bad;
  logic               age_ok;
  logic               colour_ok;
  logic signed [33:0] px;
  logic signed [33:0] py;
  logic [32:0]        d2_next;
  logic               range_ok;

  always_ff @(posedge clk) begin
    if (rst) begin
      ref_x_mm         <= '0;
      ref_y_mm         <= '0;
      colour_filter_on <= 1'b1;
      own_colour_red   <= 1'b1;
      range_limit_mm   <= '0;
      age_limit_ms     <= '0;
      now_ms           <= '0;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        REG_REF_X:       ref_x_mm         <= cfg_data[15:0];
        REG_REF_Y:       ref_y_mm         <= cfg_data[15:0];
        REG_COLOUR_ON:   colour_filter_on <= cfg_data[0];
        REG_OWN_RED:     own_colour_red   <= cfg_data[0];
        REG_RANGE_LIMIT: range_limit_mm   <= cfg_data[15:0];
        REG_AGE_LIMIT:   age_limit_ms     <= cfg_data[31:0];
        REG_NOW:         now_ms           <= cfg_data[31:0];
        default:         ;
      endcase
    end
  end

  // Square the range limit in its own register, off the item path
  always_ff @(posedge clk) begin
    range_sq <= range_limit_mm * range_limit_mm;
  end

  assign cand    = item_counter < CNT_W'(MAX_OBJECTS);
  assign cnt_ext = {8'd0, item_counter};

  always_ff @(posedge clk) begin
    if (rst) begin
      item_counter <= '0;
    end else if (take) begin
      if (last_item) begin
        item_counter <= '0;
      end else if (cand) begin
        item_counter <= item_counter + CNT_W'(1);
      end
    end
  end

  always_comb begin
    dx_next   = $signed({obj_x_mm[15], obj_x_mm}) - $signed({ref_x_mm[15], ref_x_mm});
    dy_next   = $signed({obj_y_mm[15], obj_y_mm}) - $signed({ref_y_mm[15], ref_y_mm});
    age_diff  = {1'b0, now_ms} - {1'b0, seen_ms};
    // A negative age (stamp ahead of now) always passes
    age_bad   = !age_diff[32] && (age_diff[31:0] > age_limit_ms);
    age_ok    = (age_limit_ms == '0) || (seen_ms == '0) || !age_bad;
    colour_ok = !colour_filter_on || (obj_red == own_colour_red);
  end

  assign px       = dx1 * dx1;
  assign py       = dy1 * dy1;
  assign d2_next  = {1'b0, sqx2} + {1'b0, sqy2};
  assign range_ok = (range_limit_mm == '0) || (d2_next <= {1'b0, range_sq});

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      v1 <= take;
      v2 <= v1;
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    dx1   <= dx_next;
    dy1   <= dy_next;
    ok1   <= cand && age_ok && colour_ok;
    last1 <= last_item;
    pos1  <= cnt_ext[7:0];

    sqx2  <= px[31:0];
    sqy2  <= py[31:0];
    ok2   <= ok1;
    last2 <= last1;
    pos2  <= pos1;

    ent3.pass <= ok2 && range_ok;
    ent3.last <= last2;
    ent3.pos  <= pos2;
    ent3.d2   <= d2_next;
  end

  assign push.valid = v3;
  assign push.entry = ent3;
  assign inflight   = {1'b0, v1} + {1'b0, v2} + {1'b0, v3};

endmodule

`default_nettype wire

FILE: sv/fnos_back.sv
// Back end: running minimum over classified objects and the result register.
// Depends on fnos_pkg and the shared assertion macros.
`default_nettype none
`include "filtered_nearest_object_search_macros.svh"

module fnos_back (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire fnos_pkg::queue_entry_t head,
  input  wire logic                   head_valid,
  output logic                        pop,
  output logic                        out_valid,
  input  wire logic                   out_stall,
  output logic                        found,
  output logic [7:0]                  best_index,
  output logic [33:0]                 best_dist_sq
);
  import fnos_pkg::*;

  logic [33:0] best_distance_sq;
  logic [7:0]  best_position;
  logic        any_found;

  logic [33:0] best_distance_sq_next;
  logic [7:0]  best_position_next;
  logic        any_found_next;
  logic        better;
  logic        out_free;

  // Hold a last word while the previous result still waits
  assign out_free = !out_valid || !out_stall;
  assign pop      = head_valid && (!head.last || out_free);
  assign better   = head.pass && ({1'b0, head.d2} < best_distance_sq);

  always_comb begin
    best_distance_sq_next = best_distance_sq;
    best_position_next    = best_position;
    any_found_next        = any_found;
    if (better) begin
      best_distance_sq_next = {1'b0, head.d2};
      best_position_next    = head.pos;
      any_found_next        = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      best_distance_sq <= '1;
      best_position    <= '0;
      any_found        <= 1'b0;
      out_valid        <= 1'b0;
    end else begin
      if (pop) begin
        if (head.last) begin
          best_distance_sq <= '1;
          best_position    <= '0;
          any_found        <= 1'b0;
        end else begin
          best_distance_sq <= best_distance_sq_next;
          best_position    <= best_position_next;
          any_found        <= any_found_next;
        end
      end
      if (pop && head.last) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop && head.last) begin
      found        <= any_found_next;
      best_index   <= any_found_next ? best_position_next : 8'd0;
      best_dist_sq <= any_found_next ? best_distance_sq_next : 34'd0;
    end
  end

  `FNOS_ASSERT(a_empty_result, (out_valid && !found) |-> (best_index == 8'd0 && best_dist_sq == 34'd0), "empty result not zero")
  `FNOS_NEVER(a_no_clobber, pop && head.last && out_valid && out_stall, "result overwritten while stalled")
  `FNOS_ASSERT(a_dist_bound, (out_valid && found) |-> (best_dist_sq[33] == 1'b0), "distance beyond range")

endmodule

`default_nettype wire
